[src/mcrq_pkg.sv]
// ----------------------------------------------------------------------------
// mcrq_pkg
// Shared types, constants and a helper function of the multi-channel ring queue.
// ----------------------------------------------------------------------------
package mcrq_pkg;

	localparam int NUM_QUEUES = 8;
	localparam int DEPTH      = 16;

	localparam int QID_W      = $clog2(NUM_QUEUES);
	localparam int PTR_W      = 4;
	localparam int CNT_W      = 5;
	localparam int LEN_W      = 5;
	localparam int ADDR_W     = QID_W + PTR_W;
	localparam int WORD_W     = 32;
	localparam int ID_W       = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = NUM_QUEUES * LEN_W;

	typedef enum logic [1:0] {
		CMD_SEND    = 2'd0,
		CMD_RECEIVE = 2'd1,
		CMD_EMPTY   = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NOT_RUNNING = 3'd1,
		ST_BAD_ID      = 3'd2,
		ST_NO_ACCESS   = 3'd3,
		ST_FULL        = 3'd4,
		ST_NO_DATA     = 3'd5
	} status_t;

	localparam logic [CFG_IDX_W-1:0] REG_RUNNING = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASK    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTHS = 3'd3;

	typedef struct packed {
		logic                  running;
		logic [3:0]            count;
		logic [7:0]            mask;
		logic [CFG_DATA_W-1:0] lengths;
	} cfg_t;

	typedef struct packed {
		logic [PTR_W-1:0] head;
		logic [PTR_W-1:0] tail;
		logic [CNT_W-1:0] count;
	} desc_t;

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr,
		input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] nxt;
		nxt = LEN_W'(ptr) + 1'b1;
		return (nxt >= len) ? '0 : nxt[PTR_W-1:0];
	endfunction

endpackage

[src/multi_channel_ring_queue.sv]
// ----------------------------------------------------------------------------
// multi_channel_ring_queue
// Bank of independent circular word queues with send, receive and empty.
// ----------------------------------------------------------------------------
// A command is transferred when start is high and busy is low; command,
// queue_id and data_in are sampled at that edge. Every command produces
// exactly one result: done is high for one cycle while status and data_out
// hold the result, and the receiver takes it at the end of that cycle.
// The command is registered at the transfer edge together with the
// descriptor read; the check, pointer update and word store access follow
// in the lookup state, and done is shown in the result state, where the
// registered word store read supplies data_out.
// A new command is accepted in the same cycle that done is shown, but not
// while the previous one is in the lookup state, as the descriptor
// read-modify-write loop must close first. Busy is high only in that state.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data;
// cfg_ready is always high. The user must change configuration only
// while idle; the block does not enforce this. Reset clears all queue
// pointers and counts, restores register defaults and leaves the block ready.
// ----------------------------------------------------------------------------
module multi_channel_ring_queue
	import mcrq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            command,
	input  logic [ID_W-1:0]       queue_id,
	input  logic [WORD_W-1:0]     data_in,
	output logic                  done,
	output logic [2:0]            status,
	output logic [WORD_W-1:0]     data_out,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_RESULT
	} state_t;

	state_t            state_q;
	cmd_t              cmd_s1;
	logic [ID_W-1:0]   qid_s1;
	logic [WORD_W-1:0] data_s1;
	status_t           status_q;
	logic              take_word_q;

	cfg_t              cfg;
	desc_t             desc_rd;
	desc_t             desc_wr;
	logic              desc_wr_en;
	logic              word_wr_en;
	logic              word_rd_en;
	logic [ADDR_W-1:0] word_wr_addr;
	logic [ADDR_W-1:0] word_rd_addr;
	logic [WORD_W-1:0] word_rd;
	logic              accept;

	logic [QID_W-1:0]  qidx;
	logic [LEN_W-1:0]  raw_len;
	logic [LEN_W-1:0]  len;
	logic              id_ok;
	status_t           status_d;
	logic              take_word_d;

	assign accept    = start && !busy;
	assign busy      = (state_q == S_LOOKUP);
	assign cfg_ready = 1'b1;

	mcrq_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	mcrq_desc_ram u_desc (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (queue_id[QID_W-1:0]),
		.wr_en   (desc_wr_en),
		.wr_addr (qidx),
		.wr_data (desc_wr),
		.rd_data (desc_rd)
	);

	mcrq_word_ram #(
		.ADDR_W (ADDR_W),
		.DATA_W (WORD_W)
	) u_words (
		.clk     (clk),
		.wr_en   (word_wr_en),
		.wr_addr (word_wr_addr),
		.wr_data (data_s1),
		.rd_en   (word_rd_en),
		.rd_addr (word_rd_addr),
		.rd_data (word_rd)
	);

	always_comb begin
		qidx         = qid_s1[QID_W-1:0];
		raw_len      = cfg.lengths[LEN_W*qidx +: LEN_W];
		len          = (raw_len > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : raw_len;
		id_ok        = (qid_s1 < ID_W'(cfg.count)) && (qid_s1 < ID_W'(NUM_QUEUES));
		status_d     = ST_OK;
		take_word_d  = 1'b0;
		desc_wr      = desc_rd;
		desc_wr_en   = 1'b0;
		word_wr_en   = 1'b0;
		word_rd_en   = 1'b0;
		word_wr_addr = {qidx, desc_rd.tail};
		word_rd_addr = {qidx, desc_rd.head};
		if (!cfg.running) begin
			status_d = ST_NOT_RUNNING;
		end else if (!id_ok) begin
			status_d = ST_BAD_ID;
		end else if (!cfg.mask[qidx]) begin
			status_d = ST_NO_ACCESS;
		end else begin
			case (cmd_s1)
				CMD_SEND: begin
					if (desc_rd.count >= len) begin
						status_d = ST_FULL;
					end else begin
						word_wr_en    = (state_q == S_LOOKUP);
						desc_wr_en    = (state_q == S_LOOKUP);
						desc_wr.tail  = advance(desc_rd.tail, len);
						desc_wr.count = desc_rd.count + 1'b1;
					end
				end
				CMD_RECEIVE: begin
					if (desc_rd.count == '0) begin
						status_d = ST_NO_DATA;
					end else begin
						take_word_d   = 1'b1;
						word_rd_en    = (state_q == S_LOOKUP);
						desc_wr_en    = (state_q == S_LOOKUP);
						desc_wr.head  = advance(desc_rd.head, len);
						desc_wr.count = desc_rd.count - 1'b1;
					end
				end
				CMD_EMPTY: begin
					desc_wr_en = (state_q == S_LOOKUP);
					desc_wr    = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd_t'(command);
			qid_s1  <= queue_id;
			data_s1 <= data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= ST_OK;
			take_word_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					state_q     <= S_RESULT;
					status_q    <= status_d;
					take_word_q <= take_word_d;
				end
				S_RESULT: begin
					state_q <= accept ? S_LOOKUP : S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done     = (state_q == S_RESULT);
	assign status   = status_q;
	assign data_out = take_word_q ? word_rd : '0;

endmodule

[src/mcrq_word_ram.sv]
// ----------------------------------------------------------------------------
// mcrq_word_ram
// Single-port-write, registered-read word memory holding the queue contents.
// ----------------------------------------------------------------------------
module mcrq_word_ram #(
	parameter int ADDR_W = 7,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [2**ADDR_W];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[src/mcrq_desc_ram.sv]
// ----------------------------------------------------------------------------
// mcrq_desc_ram
// Per-queue descriptor memory (head, tail, fill count) with registered read.
// Entries not written since reset read as zero.
// ----------------------------------------------------------------------------
module mcrq_desc_ram
	import mcrq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [QID_W-1:0] rd_addr,
	input  logic             wr_en,
	input  logic [QID_W-1:0] wr_addr,
	input  desc_t            wr_data,
	output desc_t            rd_data
);

	desc_t                 mem [NUM_QUEUES];
	logic [NUM_QUEUES-1:0] valid_q;
	desc_t                 rd_data_q;
	logic                  rd_hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_hit_q ? rd_data_q : '0;

endmodule

[src/mcrq_cfg_regs.sv]
// ----------------------------------------------------------------------------
// mcrq_cfg_regs
// Configuration register file written through the configuration channel.
// ----------------------------------------------------------------------------
module mcrq_cfg_regs
	import mcrq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.running <= 1'b0;
			cfg_q.count   <= 4'd8;
			cfg_q.mask    <= 8'hFF;
			cfg_q.lengths <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_RUNNING: cfg_q.running <= wr_data[0];
				REG_COUNT:   cfg_q.count   <= wr_data[3:0];
				REG_MASK:    cfg_q.mask    <= wr_data[7:0];
				REG_LENGTHS: cfg_q.lengths <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[test/multi_channel_ring_queue_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_ring_queue_test
// Self-checking bench for the bank of circular word queues.
// Directed tests cover the stopped block, the id and access checks, zero,
// single and clamped queue lengths and a length cut while data is held.
// Random traffic then runs under several register settings. A predictor
// keeps its own copy of every queue, and each result is compared with it.
// ----------------------------------------------------------------------------
module multi_channel_ring_queue_test;
	import mcrq_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int TIMEOUT_CYCLES = 100_000;
	localparam int PRINT_LIMIT    = 100;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef enum int {
		LEN_MIXED,
		LEN_FULL,
		LEN_OVER,
		LEN_SHORT,
		LEN_ZERO
	} len_mix_t;

	typedef struct {
		status_t           st;
		logic [WORD_W-1:0] word;
	} queue_reply_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic                  busy;
	logic [1:0]            command   = '0;
	logic [ID_W-1:0]       queue_id  = '0;
	logic [WORD_W-1:0]     data_in   = '0;
	logic                  done;
	logic [2:0]            status;
	logic [WORD_W-1:0]     data_out;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	logic                  cfg_running = 1'b0;
	logic [3:0]            cfg_count   = 4'd8;
	logic [7:0]            cfg_mask    = 8'hFF;
	logic [CFG_DATA_W-1:0] cfg_lengths = '0;

	logic [WORD_W-1:0] words [NUM_QUEUES][DEPTH];
	logic [PTR_W-1:0]  head_ptr [NUM_QUEUES];
	logic [PTR_W-1:0]  tail_ptr [NUM_QUEUES];
	logic [CNT_W-1:0]  fill_cnt [NUM_QUEUES];

	queue_reply_t awaited_replies[$];
	int           mismatch_count = 0;
	int           burst_left     = 4;
	bit           start_held     = 1'b0;

	multi_channel_ring_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.command   (command),
		.queue_id  (queue_id),
		.data_in   (data_in),
		.done      (done),
		.status    (status),
		.data_out  (data_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] idx,
		input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] nxt;
		nxt = {1'b0, idx} + 5'd1;
		return (nxt >= len) ? '0 : nxt[PTR_W-1:0];
	endfunction

	function automatic queue_reply_t queue_bank_step(input cmd_t c, input logic [ID_W-1:0] q,
		input logic [WORD_W-1:0] w);
		queue_reply_t     r;
		int               qn;
		logic [LEN_W-1:0] len;
		r.st   = ST_OK;
		r.word = '0;
		qn     = q % NUM_QUEUES;
		len    = cfg_lengths[qn*LEN_W +: LEN_W];
		if (len > LEN_W'(DEPTH))
			len = LEN_W'(DEPTH);
		if (!cfg_running) begin
			r.st = ST_NOT_RUNNING;
		end else if (q >= cfg_count || q >= NUM_QUEUES) begin
			r.st = ST_BAD_ID;
		end else if (!cfg_mask[qn]) begin
			r.st = ST_NO_ACCESS;
		end else begin
			case (c)
				CMD_SEND: begin
					if (fill_cnt[qn] >= len) begin
						r.st = ST_FULL;
					end else begin
						words[qn][tail_ptr[qn]] = w;
						tail_ptr[qn] = next_slot(tail_ptr[qn], len);
						fill_cnt[qn] = fill_cnt[qn] + 1'b1;
					end
				end
				CMD_RECEIVE: begin
					if (fill_cnt[qn] == 0) begin
						r.st = ST_NO_DATA;
					end else begin
						r.word = words[qn][head_ptr[qn]];
						head_ptr[qn] = next_slot(head_ptr[qn], len);
						fill_cnt[qn] = fill_cnt[qn] - 1'b1;
					end
				end
				CMD_EMPTY: begin
					head_ptr[qn] = '0;
					tail_ptr[qn] = '0;
					fill_cnt[qn] = '0;
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task automatic release_start();
		if (start_held) begin
			start      <= 1'b0;
			start_held  = 1'b0;
		end
	endtask

	task automatic send_command(input cmd_t c, input logic [ID_W-1:0] q,
		input logic [WORD_W-1:0] w);
		start      <= 1'b1;
		start_held  = 1'b1;
		command    <= c;
		queue_id   <= q;
		data_in    <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		awaited_replies.push_back(queue_bank_step(c, q, w));
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			release_start();
			repeat ($urandom_range(1, 5))
				@(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
		end
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		release_start();
		while (awaited_replies.size() != 0)
			@(posedge clk);
		repeat (2)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_RUNNING: cfg_running = value[0];
			REG_COUNT:   cfg_count   = value[3:0];
			REG_MASK:    cfg_mask    = value[7:0];
			REG_LENGTHS: cfg_lengths = value;
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	// Every queue is emptied here before run_traffic changes the lengths, so no stale slot is read later.
	task automatic clear_all_queues();
		write_register(REG_RUNNING, CFG_DATA_W'(1));
		write_register(REG_COUNT, CFG_DATA_W'(NUM_QUEUES));
		write_register(REG_MASK, CFG_DATA_W'(8'hFF));
		for (int i = 0; i < NUM_QUEUES; i++)
			send_command(CMD_EMPTY, ID_W'(i), $urandom());
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_lengths(input len_mix_t mix);
		logic [CFG_DATA_W-1:0] v;
		logic [LEN_W-1:0]      f;
		v = '0;
		for (int i = 0; i < NUM_QUEUES; i++) begin
			case (mix)
				LEN_FULL:  f = LEN_W'(DEPTH);
				LEN_OVER:  f = LEN_W'($urandom_range(DEPTH + 1, 31));
				LEN_SHORT: f = LEN_W'($urandom_range(1, 3));
				LEN_ZERO:  f = '0;
				default: begin
					case ($urandom_range(0, 4))
						0:       f = '0;
						1:       f = LEN_W'($urandom_range(1, 4));
						2:       f = LEN_W'($urandom_range(5, DEPTH - 1));
						3:       f = LEN_W'(DEPTH);
						default: f = LEN_W'($urandom_range(DEPTH + 1, 31));
					endcase
				end
			endcase
			v[i*LEN_W +: LEN_W] = f;
		end
		return v;
	endfunction

	task automatic test_stopped_block();
		send_command(CMD_SEND, 8'd0, 32'h0000_0000);
		send_command(CMD_RECEIVE, 8'hFF, 32'hFFFF_FFFF);
		send_command(CMD_EMPTY, 8'd7, 32'hA5A5_5A5A);
		send_command(CMD_NONE, 8'd8, 32'h5A5A_A5A5);
	endtask

	task automatic test_access_checks();
		write_register(REG_RUNNING, CFG_DATA_W'(1));
		send_command(CMD_SEND, 8'd8, 32'h0000_0001);
		send_command(CMD_RECEIVE, 8'hFF, 32'h8000_0000);
		write_register(REG_COUNT, CFG_DATA_W'(3));
		send_command(CMD_EMPTY, 8'd3, 32'h0);
		send_command(CMD_RECEIVE, 8'd2, 32'h0);
		write_register(REG_COUNT, CFG_DATA_W'(0));
		send_command(CMD_NONE, 8'd0, 32'h0);
		write_register(REG_COUNT, CFG_DATA_W'(NUM_QUEUES));
		write_register(REG_MASK, CFG_DATA_W'(8'h7F));
		send_command(CMD_SEND, 8'd7, 32'h1234_5678);
		send_command(CMD_SEND, 8'd6, 32'h8765_4321);
		write_register(REG_SPARE_LO, '1);
		write_register(REG_SPARE_HI, '0);
		send_command(CMD_NONE, 8'd6, 32'hFFFF_FFFF);
	endtask

	task automatic test_queue_lengths();
		logic [CFG_DATA_W-1:0] v;
		v = '0;
		v[1*LEN_W +: LEN_W] = 5'd1;
		v[2*LEN_W +: LEN_W] = 5'd31;
		write_register(REG_MASK, CFG_DATA_W'(8'hFF));
		write_register(REG_LENGTHS, v);
		send_command(CMD_SEND, 8'd0, 32'hDEAD_BEEF);
		send_command(CMD_RECEIVE, 8'd0, 32'h0);
		send_command(CMD_SEND, 8'd1, 32'hFFFF_FFFF);
		send_command(CMD_SEND, 8'd1, 32'h0BAD_F00D);
		send_command(CMD_RECEIVE, 8'd1, 32'h0);
		send_command(CMD_RECEIVE, 8'd1, 32'h0);
		send_command(CMD_SEND, 8'd2, 32'h0000_0000);
		send_command(CMD_NONE, 8'd2, 32'hC0FF_EE00);
		send_command(CMD_EMPTY, 8'd2, 32'h0);
		send_command(CMD_RECEIVE, 8'd2, 32'h0);
	endtask

	task automatic test_shrink_with_data();
		logic [CFG_DATA_W-1:0] v;
		v = '0;
		v[5*LEN_W +: LEN_W] = 5'd2;
		write_register(REG_LENGTHS, v);
		send_command(CMD_SEND, 8'd5, 32'h1357_9BDF);
		send_command(CMD_SEND, 8'd5, 32'h2468_ACE0);
		v[5*LEN_W +: LEN_W] = 5'd1;
		write_register(REG_LENGTHS, v);
		send_command(CMD_SEND, 8'd5, 32'h7777_7777);
		send_command(CMD_RECEIVE, 8'd5, 32'h0);
		send_command(CMD_RECEIVE, 8'd5, 32'h0);
		send_command(CMD_RECEIVE, 8'd5, 32'h0);
	endtask

	task automatic run_traffic(input logic run_v, input logic [3:0] count_v,
		input logic [7:0] mask_v, input len_mix_t mix, input int send_pct, input int items);
		int              usable[$];
		int              roll;
		logic [ID_W-1:0] q;
		cmd_t            c;
		clear_all_queues();
		write_register(REG_LENGTHS, pick_lengths(mix));
		write_register(REG_COUNT, CFG_DATA_W'(count_v));
		write_register(REG_MASK, CFG_DATA_W'(mask_v));
		write_register(REG_RUNNING, CFG_DATA_W'(run_v));
		for (int i = 0; i < NUM_QUEUES; i++)
			if (i < count_v && mask_v[i])
				usable.push_back(i);
		repeat (items) begin
			roll = $urandom_range(0, 99);
			if (roll < 6 || usable.size() == 0)
				q = ID_W'($urandom_range(0, 255));
			else
				q = ID_W'(usable[$urandom_range(0, usable.size() - 1)]);
			roll = $urandom_range(0, 99);
			if (roll < send_pct)
				c = CMD_SEND;
			else if (roll < 94)
				c = CMD_RECEIVE;
			else if (roll < 97)
				c = CMD_EMPTY;
			else
				c = CMD_NONE;
			send_command(c, q, $urandom());
		end
	endtask

	task automatic test_random_traffic();
		run_traffic(1'b1, 4'd8, 8'hFF, LEN_MIXED, 47, 80);
		run_traffic(1'b1, 4'd8, 8'h05, LEN_FULL, 72, 70);
		run_traffic(1'b1, 4'($urandom_range(1, 8)), 8'($urandom_range(0, 255)),
			LEN_OVER, 65, 50);
		run_traffic(1'b1, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
			LEN_SHORT, 50, 50);
		run_traffic(1'b0, 4'd8, 8'hFF, LEN_MIXED, 50, 20);
		run_traffic(1'b1, 4'd8, 8'hFF, LEN_ZERO, 50, 20);
		run_traffic(1'b1, 4'd0, 8'hFF, LEN_MIXED, 50, 10);
		run_traffic(1'b1, 4'd15, 8'h00, LEN_MIXED, 50, 10);
		run_traffic(1'b1, 4'd8, 8'hFF, LEN_MIXED, 40, 40);
	endtask

	always @(posedge clk) begin : reply_check
		queue_reply_t want;
		if (arst_n && done) begin
			if (awaited_replies.size() == 0) begin
				report_mismatch($sformatf("unexpected result, status %0d data %h",
					status, data_out));
			end else begin
				want = awaited_replies.pop_front();
				if (status !== want.st)
					report_mismatch($sformatf("status %0d, wanted %0d", status, want.st));
				if (data_out !== want.word)
					report_mismatch($sformatf("data_out %h, wanted %h", data_out, want.word));
			end
		end
	end

	initial begin
		for (int i = 0; i < NUM_QUEUES; i++) begin
			head_ptr[i] = '0;
			tail_ptr[i] = '0;
			fill_cnt[i] = '0;
		end
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_stopped_block();
		test_access_checks();
		test_queue_lengths();
		test_shrink_with_data();
		test_random_traffic();
		release_start();
		while (awaited_replies.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

[files.f]
src/mcrq_pkg.sv
src/mcrq_word_ram.sv
src/mcrq_desc_ram.sv
src/mcrq_cfg_regs.sv
src/multi_channel_ring_queue.sv
test/multi_channel_ring_queue_test.sv
